FILE: hw/rtl/stkl_pkg.sv
// ----------------------------------------------------------------------------
// stkl_pkg: shared types and constants of the sorted time key list
// Capacity, widths, request kinds, status codes and the cell control group.
// ----------------------------------------------------------------------------
package stkl_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 17;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int OUT_CNT_W = 5;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		KIND_INSERT = 3'd0,
		KIND_DELETE = 3'd1,
		KIND_LOOKUP = 3'd2,
		KIND_REWIND = 3'd3,
		KIND_NEXT   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2,
		ST_END     = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RUN  = 1'b1
	} state_t;

	typedef struct packed {
		logic ins_en;
		logic del_en;
		logic found;
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/stkl_cell.sv
// ----------------------------------------------------------------------------
// stkl_cell: one slot of the sorted key chain
// Holds one key, compares it with the request key and takes the request key
// or a neighbour's key on insert and delete.
// ----------------------------------------------------------------------------
module stkl_cell
	import stkl_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  key_t       req_key,
	input  logic       occ,
	input  logic       lt_left,
	input  key_t       left_key,
	input  key_t       right_key,
	output logic       lt,
	output logic       hit,
	output key_t       key
);

	key_t key_q;

	assign key = key_q;
	assign lt  = occ && (key_q < req_key);
	assign hit = occ && lt_left && !lt && (key_q == req_key);

	always_ff @(posedge clk) begin
		if (ctrl.ins_en && !lt) begin
			key_q <= lt_left ? req_key : left_key;
		end else if (ctrl.del_en && ctrl.found && !lt) begin
			key_q <= right_key;
		end
	end

endmodule

FILE: hw/rtl/sorted_time_key_list_top.sv
// ----------------------------------------------------------------------------
// sorted_time_key_list_top: sorted list of time-of-day keys
// A request is accepted into the busy state, in which the whole row of cells
// compares against the key and shifts at once. The result is registered as
// busy falls and is held for one cycle with done high; the receiver cannot
// stall it, and a new request may be started in that same cycle.
// ----------------------------------------------------------------------------
module sorted_time_key_list_top
	import stkl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           kind,
	input  logic [5:0]           key_seconds,
	input  logic [5:0]           key_minutes,
	input  logic [4:0]           key_hours,
	output logic                 done,
	output logic [1:0]           status,
	output logic                 found,
	output logic [5:0]           entry_seconds,
	output logic [5:0]           entry_minutes,
	output logic [4:0]           entry_hours,
	output logic [OUT_CNT_W-1:0] entry_count
);

	state_t state_q, state_d;
	logic [2:0] kind_q;
	key_t req_key_q;
	cnt_t count_q, count_d;
	cnt_t cursor_q, cursor_d;

	logic done_q;
	logic [1:0] status_q, status_d;
	logic found_q, found_d;
	key_t entry_q, entry_d;
	logic [OUT_CNT_W-1:0] count_out_q;

	cell_ctrl_t ctrl;
	logic [CAPACITY-1:0] lt_v, hit_v, occ_v, sel_v;
	key_t cell_key [CAPACITY];
	key_t sel_key;
	logic any_hit;
	logic run;

	assign run     = (state_q == S_RUN);
	assign busy    = run;
	assign any_hit = |hit_v;

	assign ctrl.ins_en = run && (kind_q == KIND_INSERT) && (count_q < cnt_t'(CAPACITY));
	assign ctrl.del_en = run && (kind_q == KIND_DELETE);
	assign ctrl.found  = any_hit;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ_v[i] = count_q > cnt_t'(i);
		assign sel_v[i] = cursor_q == cnt_t'(i);
		stkl_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.req_key   (req_key_q),
			.occ       (occ_v[i]),
			.lt_left   ((i == 0) ? 1'b1 : lt_v[(i == 0) ? 0 : i-1]),
			.left_key  (cell_key[(i == 0) ? 0 : i-1]),
			.right_key (cell_key[(i == CAPACITY-1) ? i : i+1]),
			.lt        (lt_v[i]),
			.hit       (hit_v[i]),
			.key       (cell_key[i])
		);
	end

	always_comb begin
		sel_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			sel_key = sel_key | (sel_v[i] ? cell_key[i] : key_t'(0));
		end
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		cursor_d = cursor_q;
		status_d = ST_OK;
		found_d  = 1'b0;
		entry_d  = '0;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_RUN;
			end
			S_RUN: begin
				state_d = S_IDLE;
				case (kind_q)
					KIND_INSERT: begin
						cursor_d = '0;
						if (ctrl.ins_en) count_d = count_q + cnt_t'(1);
						else status_d = ST_FULL;
					end
					KIND_DELETE: begin
						cursor_d = '0;
						if (any_hit) count_d = count_q - cnt_t'(1);
						else status_d = ST_MISSING;
					end
					KIND_LOOKUP: found_d = any_hit;
					KIND_REWIND: cursor_d = '0;
					KIND_NEXT: begin
						if (cursor_q < count_q) begin
							entry_d  = sel_key;
							cursor_d = cursor_q + cnt_t'(1);
						end else begin
							status_d = ST_END;
						end
					end
					default: ;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			cursor_q <= cursor_d;
			done_q   <= run;
		end
	end

	always_ff @(posedge clk) begin
		if (!run && start) begin
			kind_q    <= kind;
			req_key_q <= {key_hours, key_minutes, key_seconds};
		end
		if (run) begin
			status_q    <= status_d;
			found_q     <= found_d;
			entry_q     <= entry_d;
			count_out_q <= OUT_CNT_W'(count_d);
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign found         = found_q;
	assign entry_seconds = entry_q[5:0];
	assign entry_minutes = entry_q[11:6];
	assign entry_hours   = entry_q[16:12];
	assign entry_count   = count_out_q;

endmodule

FILE: hw/rtl/stkl_checker.sv
// ----------------------------------------------------------------------------
// stkl_checker: port-level checks of the sorted time key list
// Request timing, result strobe spacing and result field consistency.
// ----------------------------------------------------------------------------
module stkl_checker
	import stkl_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic       found,
	input logic [5:0] entry_seconds,
	input logic [5:0] entry_minutes,
	input logic [4:0] entry_hours
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted without going busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("busy request did not deliver a result next cycle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_END) |->
			(entry_seconds == 6'd0) && (entry_minutes == 6'd0) && (entry_hours == 5'd0))
		else $error("entry fields not cleared on end of list");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == ST_OK)
		else $error("found set with an error status");

endmodule

bind sorted_time_key_list_top stkl_checker u_stkl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.found         (found),
	.entry_seconds (entry_seconds),
	.entry_minutes (entry_minutes),
	.entry_hours   (entry_hours)
);
